@@ rtl/rv2m_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rv2m_pkg;

	localparam int IN_WIDTH  = 16;
	localparam int OUT_WIDTH = 16;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] axis_x;
		logic signed [IN_WIDTH-1:0] axis_y;
		logic signed [IN_WIDTH-1:0] axis_z;
	} in_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] m00;
		logic signed [OUT_WIDTH-1:0] m01;
		logic signed [OUT_WIDTH-1:0] m02;
		logic signed [OUT_WIDTH-1:0] m10;
		logic signed [OUT_WIDTH-1:0] m11;
		logic signed [OUT_WIDTH-1:0] m12;
		logic signed [OUT_WIDTH-1:0] m20;
		logic signed [OUT_WIDTH-1:0] m21;
		logic signed [OUT_WIDTH-1:0] m22;
		logic                        zero_axis;
	} out_t;

	// arctan(2^-i) in q30
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:    a = 32'd843314857;
			5'd1:    a = 32'd497837829;
			5'd2:    a = 32'd263043837;
			5'd3:    a = 32'd133525159;
			5'd4:    a = 32'd67021687;
			5'd5:    a = 32'd33543516;
			5'd6:    a = 32'd16775851;
			5'd7:    a = 32'd8388437;
			5'd8:    a = 32'd4194283;
			5'd9:    a = 32'd2097149;
			5'd10:   a = 32'd1048576;
			5'd11:   a = 32'd524288;
			5'd12:   a = 32'd262144;
			5'd13:   a = 32'd131072;
			5'd14:   a = 32'd65536;
			5'd15:   a = 32'd32768;
			5'd16:   a = 32'd16384;
			5'd17:   a = 32'd8192;
			5'd18:   a = 32'd4096;
			5'd19:   a = 32'd2048;
			5'd20:   a = 32'd1024;
			5'd21:   a = 32'd512;
			5'd22:   a = 32'd256;
			5'd23:   a = 32'd128;
			5'd24:   a = 32'd64;
			5'd25:   a = 32'd32;
			5'd26:   a = 32'd16;
			5'd27:   a = 32'd8;
			5'd28:   a = 32'd4;
			5'd29:   a = 32'd2;
			5'd30:   a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

@@ rtl/rotation_vector_to_matrix.sv @@
// throughput: one item per cycle while the skid register is empty; every step (square root bit, quotient bit,
// cordic rotation) has its own pipeline stage, so nothing is shared between items
// a full skid register freezes the whole pipeline; in_ready comes straight from it
// reset (arst_n low) clears all valid flags and the skid/output state; data is not reset
`timescale 1ns / 1ps
`default_nettype none

module rotation_vector_to_matrix #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rv2m_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rv2m_pkg::out_t   out_data
);
	import rv2m_pkg::*;

	localparam int CN   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int SQ_N = 32;
	localparam int DV_N = 31;
	localparam int EOFS = 34 - IN_WIDTH;
	localparam int SH   = 32 - OUT_WIDTH;

	localparam logic [34:0]        TWO_PI    = 35'd6746518852;
	localparam logic [34:0]        FOUR_PI   = 35'd13493037704;
	localparam logic signed [34:0] PI_S      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_S = 35'sd1686629713;
	localparam logic signed [34:0] TWO_PI_S  = 35'sd6746518852;
	localparam logic signed [34:0] FOLD_HI   = 35'sd5059889139;
	localparam logic signed [33:0] GAIN      = 34'sd652032874;
	localparam logic signed [34:0] ONE_Q30   = 35'sd1073741824;
	localparam logic signed [36:0] LIM       = 37'sd1 <<< (OUT_WIDTH - 2);
	localparam logic signed [36:0] RND       = (37'sd1 <<< SH) >>> 1;

	typedef struct packed {
		logic             zero;
		logic [2:0]       neg;
		logic [4:0]       k;
		logic [2:0][31:0] av;
	} nrm_t;

	typedef struct packed {
		logic             zero;
		logic [2:0]       neg;
		logic [34:0]      ang;
		logic [31:0]      r;
		logic [2:0][61:0] num;
	} dvs_t;

	typedef struct packed {
		logic             zero;
		logic             flip;
		logic [2:0][31:0] u;
	} pd_t;

	function automatic logic signed [34:0] mq(input logic signed [34:0] a,
		input logic signed [34:0] b);
		logic signed [69:0] p;
		p = a * b + (70'sd1 <<< 29);
		return 35'(p >>> 30);
	endfunction

	function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [36:0] m);
		logic signed [36:0] v;
		v = (m + RND) >>> SH;
		if (v > LIM)
			v = LIM;
		else if (v < -LIM)
			v = -LIM;
		return OUT_WIDTH'(v);
	endfunction

	logic en;
	logic skid_v_q;
	out_t skid_q;
	out_t fmt;

	assign en       = !skid_v_q;
	assign in_ready = en;

	// ---------------- front end: magnitude, normalize, square, sum
	logic signed [IN_WIDTH-1:0] ax_c [3];
	logic [IN_WIDTH-1:0]        abs_c [3];
	logic [IN_WIDTH-1:0]        mag_c;

	assign ax_c[0] = in_data.axis_x;
	assign ax_c[1] = in_data.axis_y;
	assign ax_c[2] = in_data.axis_z;

	always_comb begin
		mag_c = '0;
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = ax_c[i][IN_WIDTH-1] ? (~ax_c[i] + 1'b1) : ax_c[i];
			if (abs_c[i] > mag_c)
				mag_c = abs_c[i];
		end
	end

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [IN_WIDTH-1:0] abs_s1 [3];
	logic [2:0]          neg_s1;
	logic [IN_WIDTH-1:0] mag_s1;
	nrm_t                nb_s2, nb_s3, nb_s4;
	logic [63:0]         sq_s3 [3];
	logic [63:0]         sum_s4;

	logic [IN_WIDTH-1:0] dm_c;
	logic [5:0]          q_c;
	logic [4:0]          k_c;
	nrm_t                nb_c;

	// shift so the largest magnitude lands in (2^30, 2^31]
	always_comb begin
		dm_c = mag_s1 - 1'b1;
		q_c  = '0;
		for (int b = 0; b < IN_WIDTH; b++) begin
			if (dm_c[b])
				q_c = 6'(b + 1);
		end
		k_c = 5'(6'd31 - q_c);
		nb_c.zero = (mag_s1 == '0);
		nb_c.neg  = neg_s1;
		nb_c.k    = k_c;
		for (int i = 0; i < 3; i++)
			nb_c.av[i] = 32'(abs_s1[i]) << k_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				abs_s1[i] <= abs_c[i];
				neg_s1[i] <= ax_c[i][IN_WIDTH-1];
				sq_s3[i]  <= nb_s2.av[i] * nb_s2.av[i];
			end
			mag_s1 <= mag_c;
			nb_s2  <= nb_c;
			nb_s3  <= nb_s2;
			nb_s4  <= nb_s3;
			sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		end
	end

	// ---------------- square root, one root bit per stage
	logic        sqr_v_s    [SQ_N];
	logic [33:0] sqr_rem_s  [SQ_N];
	logic [31:0] sqr_root_s [SQ_N];
	logic [63:0] sqr_rad_s  [SQ_N];
	nrm_t        sqr_nb_s   [SQ_N];

	for (genvar j = 0; j < SQ_N; j++) begin : g_sqr
		logic        v_p;
		logic [33:0] rem_p;
		logic [31:0] root_p;
		logic [63:0] rad_p;
		nrm_t        nb_p;
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;

		if (j == 0) begin : g_first
			assign v_p    = v_s4;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = sum_s4;
			assign nb_p   = nb_s4;
		end else begin : g_next
			assign v_p    = sqr_v_s[j-1];
			assign rem_p  = sqr_rem_s[j-1];
			assign root_p = sqr_root_s[j-1];
			assign rad_p  = sqr_rad_s[j-1];
			assign nb_p   = sqr_nb_s[j-1];
		end

		assign cur   = {rem_p, rad_p[63-2*j -: 2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqr_v_s[j] <= 1'b0;
			else if (en)
				sqr_v_s[j] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqr_rem_s[j]  <= ge ? 34'(cur - trial) : 34'(cur);
				sqr_root_s[j] <= {root_p[30:0], ge};
				sqr_rad_s[j]  <= rad_p;
				sqr_nb_s[j]   <= nb_p;
			end
		end
	end

	// ---------------- angle and rounded dividends
	logic        v_s5;
	dvs_t        dv_s5;
	dvs_t        dv_c;
	logic [31:0] r_c;
	nrm_t        nb_l;
	logic [5:0]  eo_c;
	logic [5:0]  k6_c;

	assign r_c  = sqr_root_s[SQ_N-1];
	assign nb_l = sqr_nb_s[SQ_N-1];
	assign eo_c = 6'(EOFS);
	assign k6_c = {1'b0, nb_l.k};

	always_comb begin
		dv_c.zero = nb_l.zero;
		dv_c.neg  = nb_l.neg;
		dv_c.r    = r_c;
		if (k6_c <= eo_c)
			dv_c.ang = {3'b000, r_c} << (eo_c - k6_c);
		else
			dv_c.ang = {3'b000, r_c} >> (k6_c - eo_c);
		for (int i = 0; i < 3; i++)
			dv_c.num[i] = {nb_l.av[i], 30'd0} + {31'd0, r_c[31:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= sqr_v_s[SQ_N-1];
	end

	always_ff @(posedge clk) begin
		if (en)
			dv_s5 <= dv_c;
	end

	// ---------------- three restoring dividers, one quotient bit per stage
	logic        dvd_v_s   [DV_N];
	logic [31:0] dvd_rem_s [DV_N][3];
	logic [30:0] dvd_q_s   [DV_N][3];
	dvs_t        dvd_sb_s  [DV_N];

	for (genvar j = 0; j < DV_N; j++) begin : g_div
		logic        v_p;
		logic [31:0] rem_p [3];
		logic [30:0] q_p   [3];
		dvs_t        sb_p;
		logic [32:0] cur   [3];
		logic        ge    [3];

		if (j == 0) begin : g_first
			assign v_p  = v_s5;
			assign sb_p = dv_s5;
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_p[i] = {1'b0, dv_s5.num[i][61:31]};
					q_p[i]   = '0;
				end
			end
		end else begin : g_next
			assign v_p  = dvd_v_s[j-1];
			assign sb_p = dvd_sb_s[j-1];
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_p[i] = dvd_rem_s[j-1][i];
					q_p[i]   = dvd_q_s[j-1][i];
				end
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				cur[i] = {rem_p[i], sb_p.num[i][30-j]};
				ge[i]  = (cur[i] >= {1'b0, sb_p.r});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvd_v_s[j] <= 1'b0;
			else if (en)
				dvd_v_s[j] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dvd_rem_s[j][i] <= ge[i] ? 32'(cur[i] - {1'b0, sb_p.r}) : 32'(cur[i]);
					dvd_q_s[j][i]   <= {q_p[i][29:0], ge[i]};
				end
				dvd_sb_s[j] <= sb_p;
			end
		end
	end

	// ---------------- signed axis, angle mod 2pi, fold to +-pi/2
	logic        v_s6, v_s7;
	pd_t         pd_s6, pd_s7;
	logic [32:0] z_s6;
	logic signed [34:0] z_s7;
	pd_t         pd_c;
	logic [32:0] zm_c;
	dvs_t        sb_l;
	logic signed [34:0] zs_c;
	logic signed [34:0] zf_c;
	logic        flip_c;

	assign sb_l = dvd_sb_s[DV_N-1];

	always_comb begin
		pd_c.zero = sb_l.zero;
		pd_c.flip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (sb_l.neg[i])
				pd_c.u[i] = -{1'b0, dvd_q_s[DV_N-1][i]};
			else
				pd_c.u[i] = {1'b0, dvd_q_s[DV_N-1][i]};
		end
		if (sb_l.ang >= FOUR_PI)
			zm_c = 33'(sb_l.ang - FOUR_PI);
		else if (sb_l.ang >= TWO_PI)
			zm_c = 33'(sb_l.ang - TWO_PI);
		else
			zm_c = 33'(sb_l.ang);
	end

	always_comb begin
		zs_c = $signed({2'b00, z_s6});
		if (zs_c <= HALF_PI_S) begin
			zf_c   = zs_c;
			flip_c = 1'b0;
		end else if (zs_c < FOLD_HI) begin
			zf_c   = zs_c - PI_S;
			flip_c = 1'b1;
		end else begin
			zf_c   = zs_c - TWO_PI_S;
			flip_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= dvd_v_s[DV_N-1];
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s6 <= pd_c;
			z_s6  <= zm_c;
			pd_s7 <= '{zero: pd_s6.zero, flip: flip_c, u: pd_s6.u};
			z_s7  <= zf_c;
		end
	end

	// ---------------- cordic rotation, one micro-rotation per stage
	logic               cor_v_s  [CN];
	logic signed [33:0] cor_x_s  [CN];
	logic signed [33:0] cor_y_s  [CN];
	logic signed [34:0] cor_z_s  [CN];
	pd_t                cor_pd_s [CN];

	for (genvar i = 0; i < CN; i++) begin : g_cor
		logic               v_p;
		logic signed [33:0] x_p, y_p;
		logic signed [34:0] z_p;
		pd_t                pd_p;
		logic signed [34:0] at;

		if (i == 0) begin : g_first
			assign v_p  = v_s7;
			assign x_p  = GAIN;
			assign y_p  = '0;
			assign z_p  = z_s7;
			assign pd_p = pd_s7;
		end else begin : g_next
			assign v_p  = cor_v_s[i-1];
			assign x_p  = cor_x_s[i-1];
			assign y_p  = cor_y_s[i-1];
			assign z_p  = cor_z_s[i-1];
			assign pd_p = cor_pd_s[i-1];
		end

		assign at = $signed({3'b000, atan_q30(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cor_v_s[i] <= 1'b0;
			else if (en)
				cor_v_s[i] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_p >= 0) begin
					cor_x_s[i] <= x_p - (y_p >>> i);
					cor_y_s[i] <= y_p + (x_p >>> i);
					cor_z_s[i] <= z_p - at;
				end else begin
					cor_x_s[i] <= x_p + (y_p >>> i);
					cor_y_s[i] <= y_p - (x_p >>> i);
					cor_z_s[i] <= z_p + at;
				end
				cor_pd_s[i] <= pd_p;
			end
		end
	end

	// ---------------- products
	logic               v_s8, v_s9;
	logic signed [34:0] uu_s8 [6];
	logic signed [34:0] su_s8 [3];
	logic signed [34:0] t_s8;
	logic signed [33:0] c_s8;
	logic               zero_s8;
	logic signed [34:0] tu_s9 [6];
	logic signed [34:0] su_s9 [3];
	logic signed [33:0] c_s9;
	logic               zero_s9;

	pd_t                pd_l;
	logic signed [33:0] c_c, s_c;
	logic signed [34:0] u_c [3];

	assign pd_l = cor_pd_s[CN-1];

	always_comb begin
		c_c = pd_l.flip ? -cor_x_s[CN-1] : cor_x_s[CN-1];
		s_c = pd_l.flip ? -cor_y_s[CN-1] : cor_y_s[CN-1];
		for (int i = 0; i < 3; i++)
			u_c[i] = 35'($signed(pd_l.u[i]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s8 <= cor_v_s[CN-1];
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uu_s8[0] <= mq(u_c[0], u_c[0]);
			uu_s8[1] <= mq(u_c[0], u_c[1]);
			uu_s8[2] <= mq(u_c[0], u_c[2]);
			uu_s8[3] <= mq(u_c[1], u_c[1]);
			uu_s8[4] <= mq(u_c[1], u_c[2]);
			uu_s8[5] <= mq(u_c[2], u_c[2]);
			for (int i = 0; i < 3; i++)
				su_s8[i] <= mq(35'(s_c), u_c[i]);
			t_s8    <= ONE_Q30 - 35'(c_c);
			c_s8    <= c_c;
			zero_s8 <= pd_l.zero;
			for (int i = 0; i < 6; i++)
				tu_s9[i] <= mq(t_s8, uu_s8[i]);
			su_s9   <= su_s8;
			c_s9    <= c_s8;
			zero_s9 <= zero_s8;
		end
	end

	// ---------------- sum, round, saturate
	logic signed [36:0] cd_c;

	assign cd_c = 37'(c_s9);

	always_comb begin
		if (zero_s9) begin
			fmt     = '0;
			fmt.m00 = OUT_WIDTH'(LIM);
			fmt.m11 = OUT_WIDTH'(LIM);
			fmt.m22 = OUT_WIDTH'(LIM);
			fmt.zero_axis = 1'b1;
		end else begin
			fmt.m00 = to_out(37'(tu_s9[0]) + cd_c);
			fmt.m01 = to_out(37'(tu_s9[1]) - 37'(su_s9[2]));
			fmt.m02 = to_out(37'(tu_s9[2]) + 37'(su_s9[1]));
			fmt.m10 = to_out(37'(tu_s9[1]) + 37'(su_s9[2]));
			fmt.m11 = to_out(37'(tu_s9[3]) + cd_c);
			fmt.m12 = to_out(37'(tu_s9[4]) - 37'(su_s9[0]));
			fmt.m20 = to_out(37'(tu_s9[2]) - 37'(su_s9[1]));
			fmt.m21 = to_out(37'(tu_s9[4]) + 37'(su_s9[0]));
			fmt.m22 = to_out(37'(tu_s9[5]) + cd_c);
			fmt.zero_axis = 1'b0;
		end
	end

	// ---------------- output register with skid
	logic out_free;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (out_free) begin
			out_valid <= skid_v_q || v_s9;
			skid_v_q  <= 1'b0;
		end else if (v_s9 && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q)
				out_data <= skid_q;
			else if (v_s9)
				out_data <= fmt;
		end else if (v_s9 && !skid_v_q) begin
			skid_q <= fmt;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid)
		else $error("skid holds an item while output is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_valid && !out_ready))
		else $error("skid filled without an output stall");

	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.zero_axis) |->
		(out_data.m00 == OUT_WIDTH'(LIM) && out_data.m01 == '0 && out_data.m12 == '0))
		else $error("zero vector did not give identity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(out_data.m10) <= LIM && $signed(out_data.m10) >= -LIM))
		else $error("matrix entry outside unit range");

endmodule

`default_nettype wire
